// ===== hw/rtl/b58enc_pkg.sv =====
// b58enc_pkg: shared types, constants and helper functions of the base58 encoder
// used by the controller, the datapath and the top level; no dependencies
`default_nettype none

package b58enc_pkg;

  // ascii code of the zero digit, also emitted once per leading zero byte
  localparam logic [6:0] ZERO_SYMBOL = 7'h31;

  // number base and reciprocal of 58 scaled by 2^20 (exact for dividends below 2^14)
  localparam int unsigned BASE        = 58;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam logic [14:0] RECIP       = 15'd18079;

  // alphabet, first character in the top byte
  localparam logic [58*8-1:0] ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  // controller states
  typedef enum logic [3:0] {
    S_COLLECT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_PASS_INIT,
    S_DIV_RD,
    S_DIV_CALC,
    S_EMIT_Z,
    S_DIG_RD,
    S_DIG_LD
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic in_en;      // input channel ready
    logic clr;        // clear message counters
    logic k_zero;     // byte index to zero
    logic k_inc;      // byte index up by one
    logic byte_rd;    // read byte store at byte index
    logic set_zpc_k;  // leading zeros end at byte index
    logic set_zpc_n;  // message is all zero
    logic pass_init;  // start a division pass
    logic div_step;   // divide one byte of the pass
    logic pass_end;   // store the pass remainder as a digit
    logic emit_zero;  // load a zero symbol into the output register
    logic dig_init;   // load the digit countdown
    logic dig_rd;     // read the next digit, most significant first
    logic dig_ld;     // load the digit symbol into the output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_last_fire; // last byte of a message accepted
    logic n_reached;    // byte index equals byte count
    logic byte_zero;    // read byte is zero
    logic start_done;   // nothing left to divide
    logic k_last;       // byte index is the last byte
    logic zeros_done;   // all zero symbols emitted
    logic no_digits;    // digit count is zero
    logic out_free;     // output register can take a beat
    logic d_one;        // one digit left to emit
  } st_t;

  // quotient and remainder of one long division step
  typedef struct packed {
    logic [7:0] q;
    logic [5:0] r;
  } div_t;

  // divide a dividend below 58*256 by 58
  function automatic div_t div58(input logic [13:0] acc);
    logic [28:0] prod;
    logic [13:0] q58;
    div_t        res;
    prod  = 29'(acc) * 29'(RECIP);
    res.q = prod[RECIP_SHIFT +: 8];
    q58   = (14'(res.q) << 6) - (14'(res.q) << 2) - (14'(res.q) << 1);
    res.r = 6'(acc - q58);
    return res;
  endfunction

  // map a digit to its ascii character
  function automatic logic [6:0] digit_symbol(input logic [5:0] d);
    logic [7:0]  ch;
    int unsigned pos;
    pos = (32'(d) < BASE) ? (BASE - 1 - 32'(d)) : (BASE - 1);
    ch  = ALPHABET[pos*8 +: 8];
    return ch[6:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b58enc_in_if.sv =====
// b58enc_in_if: message byte channel with valid/ready handshake
// standalone, no package dependency
`default_nettype none

interface b58enc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/b58enc_out_if.sv =====
// b58enc_out_if: encoded symbol channel with valid/ready handshake
// standalone, no package dependency
`default_nettype none

interface b58enc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] symbol;
  logic       last_symbol;

  modport source (output valid, symbol, last_symbol, input ready);
  modport sink   (input valid, symbol, last_symbol, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/b58enc_ctrl.sv =====
// b58enc_ctrl: sequencer for collect, zero scan, division passes and emission
// depends on b58enc_pkg
`default_nettype none

module b58enc_ctrl
  import b58enc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  st_t    st_i,
  output cmd_t   cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_COLLECT: begin
        if (st_i.in_last_fire) state_d = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        state_d = st_i.n_reached ? S_EMIT_Z : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        state_d = st_i.byte_zero ? S_SCAN_RD : S_PASS_INIT;
      end
      S_PASS_INIT: begin
        state_d = st_i.start_done ? S_EMIT_Z : S_DIV_RD;
      end
      S_DIV_RD: begin
        state_d = S_DIV_CALC;
      end
      S_DIV_CALC: begin
        state_d = st_i.k_last ? S_PASS_INIT : S_DIV_RD;
      end
      S_EMIT_Z: begin
        if (st_i.zeros_done) state_d = st_i.no_digits ? S_COLLECT : S_DIG_RD;
      end
      S_DIG_RD: begin
        state_d = S_DIG_LD;
      end
      S_DIG_LD: begin
        if (st_i.out_free) state_d = st_i.d_one ? S_COLLECT : S_DIG_RD;
      end
      default: state_d = S_COLLECT;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_COLLECT: begin
        cmd_o.in_en  = 1'b1;
        cmd_o.k_zero = st_i.in_last_fire;
      end
      S_SCAN_RD: begin
        cmd_o.set_zpc_n = st_i.n_reached;
        cmd_o.byte_rd   = !st_i.n_reached;
      end
      S_SCAN_CHK: begin
        cmd_o.k_inc     = st_i.byte_zero;
        cmd_o.set_zpc_k = !st_i.byte_zero;
      end
      S_PASS_INIT: begin
        cmd_o.pass_init = !st_i.start_done;
      end
      S_DIV_RD: begin
        cmd_o.byte_rd = 1'b1;
      end
      S_DIV_CALC: begin
        cmd_o.div_step = 1'b1;
        cmd_o.pass_end = st_i.k_last;
      end
      S_EMIT_Z: begin
        if (st_i.zeros_done) begin
          cmd_o.clr      = st_i.no_digits;
          cmd_o.dig_init = !st_i.no_digits;
        end else begin
          cmd_o.emit_zero = st_i.out_free;
        end
      end
      S_DIG_RD: begin
        cmd_o.dig_rd = 1'b1;
      end
      S_DIG_LD: begin
        cmd_o.dig_ld = st_i.out_free;
        cmd_o.clr    = st_i.out_free && st_i.d_one;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/b58enc_dp.sv =====
// b58enc_dp: byte store, digit store, divide-by-58 unit, counters, output register
// depends on b58enc_pkg, b58enc_in_if and b58enc_out_if
`default_nettype none

module b58enc_dp
  import b58enc_pkg::*;
#(
  parameter int MAX_BYTES = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  output st_t           st_o,
  b58enc_in_if.sink     in_i,
  b58enc_out_if.source  out_o
);

  localparam int DIGIT_CAP = MAX_BYTES * 137 / 100 + 2;
  localparam int AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CW  = $clog2(MAX_BYTES + 1);
  localparam int DAW = $clog2(DIGIT_CAP);
  localparam int DCW = $clog2(DIGIT_CAP + 1);

  // memories
  logic [7:0] byte_mem  [MAX_BYTES];
  logic [5:0] digit_mem [DIGIT_CAP];

  logic [7:0]     rd_q;
  logic [5:0]     dig_q;
  logic [CW-1:0]  bc_q, k_q, start_q, ns_q, zpc_q, e_q;
  logic [DCW-1:0] dc_q, d_q;
  logic [5:0]     rem_q;
  logic           lead_q;
  logic           out_valid_q, out_last_q;
  logic [6:0]     out_sym_q;

  logic           in_fire, bc_room, out_free;
  div_t           div_res;
  logic [CW-1:0]  k_inc_v, ns_next;
  logic [DCW-1:0] d_m1;

  assign in_i.ready = cmd_i.in_en;
  assign in_fire    = in_i.valid && cmd_i.in_en;
  assign bc_room    = bc_q < CW'(MAX_BYTES);
  assign out_free   = !out_valid_q || out_o.ready;

  // one long division step: remainder * 256 + byte, divided by 58
  assign div_res = div58({rem_q, rd_q});
  assign k_inc_v = k_q + 1'b1;
  assign ns_next = (lead_q && (div_res.q == 8'd0)) ? k_inc_v : ns_q;
  assign d_m1    = d_q - 1'b1;

  // status
  always_comb begin
    st_o.in_last_fire = in_fire && in_i.last_byte;
    st_o.n_reached    = (k_q == bc_q);
    st_o.byte_zero    = (rd_q == 8'd0);
    st_o.start_done   = (start_q == bc_q);
    st_o.k_last       = (k_inc_v == bc_q);
    st_o.zeros_done   = (e_q == zpc_q);
    st_o.no_digits    = (dc_q == '0);
    st_o.out_free     = out_free;
    st_o.d_one        = (d_q == DCW'(1));
  end

  // byte store, written on collect and rewritten by each division step
  always_ff @(posedge clk_i) begin
    if (in_fire && bc_room) begin
      byte_mem[bc_q[AW-1:0]] <= in_i.data_byte;
    end else if (cmd_i.div_step) begin
      byte_mem[k_q[AW-1:0]] <= div_res.q;
    end
    if (cmd_i.byte_rd) begin
      rd_q <= byte_mem[k_q[AW-1:0]];
    end
  end

  // digit store, least significant first
  always_ff @(posedge clk_i) begin
    if (cmd_i.pass_end && (dc_q < DCW'(DIGIT_CAP))) begin
      digit_mem[dc_q[DAW-1:0]] <= div_res.r;
    end
    if (cmd_i.dig_rd) begin
      dig_q <= digit_mem[d_m1[DAW-1:0]];
    end
  end

  // counters and pass state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q    <= '0;
      k_q     <= '0;
      start_q <= '0;
      ns_q    <= '0;
      zpc_q   <= '0;
      e_q     <= '0;
      dc_q    <= '0;
      d_q     <= '0;
      rem_q   <= '0;
      lead_q  <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        bc_q  <= '0;
        zpc_q <= '0;
        e_q   <= '0;
        dc_q  <= '0;
      end else begin
        if (in_fire && bc_room) bc_q <= bc_q + 1'b1;
        if (cmd_i.set_zpc_k) zpc_q <= k_q;
        if (cmd_i.set_zpc_n) zpc_q <= bc_q;
        if (cmd_i.emit_zero) e_q <= e_q + 1'b1;
        if (cmd_i.pass_end && (dc_q < DCW'(DIGIT_CAP))) dc_q <= dc_q + 1'b1;
      end

      // byte index
      priority if (cmd_i.k_zero) begin
        k_q <= '0;
      end else if (cmd_i.pass_init) begin
        k_q <= start_q;
      end else if (cmd_i.k_inc || cmd_i.div_step) begin
        k_q <= k_inc_v;
      end

      // first non-zero byte of the working number
      priority if (cmd_i.set_zpc_k) begin
        start_q <= k_q;
      end else if (cmd_i.set_zpc_n) begin
        start_q <= bc_q;
      end else if (cmd_i.pass_end) begin
        start_q <= ns_next;
      end

      // running remainder and leading quotient tracking
      if (cmd_i.pass_init) begin
        rem_q  <= '0;
        lead_q <= 1'b1;
        ns_q   <= start_q;
      end else if (cmd_i.div_step) begin
        rem_q  <= div_res.r;
        lead_q <= lead_q && (div_res.q == 8'd0);
        ns_q   <= ns_next;
      end

      // digit countdown
      if (cmd_i.dig_init) begin
        d_q <= dc_q;
      end else if (cmd_i.dig_ld) begin
        d_q <= d_m1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_zero || cmd_i.dig_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_zero) begin
      out_sym_q  <= ZERO_SYMBOL;
      out_last_q <= ((e_q + 1'b1) == zpc_q) && (dc_q == '0);
    end else if (cmd_i.dig_ld) begin
      out_sym_q  <= digit_symbol(dig_q);
      out_last_q <= (d_q == DCW'(1));
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.symbol      = out_sym_q;
  assign out_o.last_symbol = out_last_q;

`ifndef ASSERT_OFF
  a_bc_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= CW'(MAX_BYTES))
    else $error("byte count beyond store depth");

  a_zpc_le_bc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zpc_q <= bc_q)
    else $error("leading zero count beyond byte count");

  a_dc_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dc_q <= DCW'(DIGIT_CAP))
    else $error("digit count beyond digit store depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_zero || cmd_i.dig_ld) |-> out_free)
    else $error("output register loaded while a beat is pending");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step || cmd_i.byte_rd || cmd_i.dig_rd) |-> !in_fire)
    else $error("byte accepted during conversion");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/base58_encoder_core.sv =====
// base58_encoder_core: top level of the base58 encoder (bitcoin alphabet)
// depends on b58enc_pkg, b58enc_in_if, b58enc_out_if, b58enc_ctrl, b58enc_dp
//
// channel  dir  payload                     meaning
// msg_i    in   data_byte[7:0], last_byte   message bytes, most significant first
// sym_o    out  symbol[6:0], last_symbol    ascii symbols, most significant first
//
// bytes are taken one per cycle while collecting; after the last byte the block is busy
// zero scan: a read state and a check state per leading zero byte; each division pass:
// an init state, then a read and a divide state per byte still non-zero, on one store port
// emission: leading '1's, then a read and a load state per digit (digit store read latency)
// output stalls hold the sequencer; reset clears counters, stores need no clearing pass
`default_nettype none

module base58_encoder_core
  import b58enc_pkg::*;
#(
  parameter int MAX_BYTES = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  b58enc_in_if.sink     msg_i,
  b58enc_out_if.source  sym_o
);

  cmd_t cmd;
  st_t  st;

  // sequencer
  b58enc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  // stores, divider and output register
  b58enc_dp #(
    .MAX_BYTES (MAX_BYTES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .st_o   (st),
    .in_i   (msg_i),
    .out_o  (sym_o)
  );

endmodule

`default_nettype wire
